@@ src/nfa_epsilon_simulator_defines.svh @@
// Assertion macros of the epsilon-NFA simulator RTL
`ifndef NFA_EPSILON_SIMULATOR_DEFINES_SVH
`define NFA_EPSILON_SIMULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NFAE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NFAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/nfae_pkg.sv @@
// Types and constants of the epsilon-NFA simulator
package nfae_pkg;

  localparam int STATE_W    = 6;
  localparam int SYM_W      = 5;
  localparam int FUNC_W     = 2;
  localparam int STAT_W     = 2;
  localparam int MAX_STATES = 64;

  localparam int DEF_NUM_STATES      = 64;
  localparam int DEF_MAX_TRANSITIONS = 128;

  // symbol codes: letters a-z are 0..25, then epsilon, then anything else
  localparam logic [SYM_W-1:0] SYM_LETTERS = 5'd26;
  localparam logic [SYM_W-1:0] SYM_EPS     = 5'd26;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_START = 2'd2,
    FN_CHAR  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP,
    ST_MOVE,
    ST_CLOSE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } ring_ctl_t;

endpackage

@@ src/nfae_in_if.sv @@
// Input item channel of the epsilon-NFA simulator
interface nfae_in_if;
  logic                         valid;
  logic                         ready;
  logic [nfae_pkg::FUNC_W-1:0]  func;
  logic [nfae_pkg::STATE_W-1:0] from_state;
  logic [nfae_pkg::STATE_W-1:0] to_state;
  logic [nfae_pkg::SYM_W-1:0]   symbol;

  modport source (output valid, output func, output from_state, output to_state,
                  output symbol, input ready);
  modport sink   (input valid, input func, input from_state, input to_state,
                  input symbol, output ready);
endinterface

@@ src/nfae_out_if.sv @@
// Result channel of the epsilon-NFA simulator
interface nfae_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accept;
  logic                        set_empty;
  logic [nfae_pkg::STAT_W-1:0] status;

  modport source (output valid, output accept, output set_empty, output status,
                  input ready);
  modport sink   (input valid, input accept, input set_empty, input status,
                  output ready);
endinterface

@@ src/nfae_cell.sv @@
// One transition-table cell of the rotating ring
module nfae_cell #(
  parameter int MAX_TRANSITIONS = nfae_pkg::DEF_MAX_TRANSITIONS,
  parameter int CELL_IDX        = 0
) (
  input  logic                  clk,
  input  nfae_pkg::ring_ctl_t   ctl,
  input  logic [(MAX_TRANSITIONS > 1 ? $clog2(MAX_TRANSITIONS) : 1)-1:0] load_idx,
  input  nfae_pkg::entry_t      load_data,
  input  nfae_pkg::entry_t      nbr_i,
  output nfae_pkg::entry_t      entry_o
);

  localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;

  nfae_pkg::entry_t entry_r;

  // load wins; the ring never shifts while a load is pending
  always_ff @(posedge clk) begin
    if (ctl.load && (load_idx == IDX_W'(CELL_IDX))) begin
      entry_r <= load_data;
    end else if (ctl.shift) begin
      entry_r <= nbr_i;
    end
  end

  assign entry_o = entry_r;

endmodule

@@ src/nfae_ctrl.sv @@
// Sequencer, active-set datapath and result register of the epsilon-NFA simulator
`include "nfa_epsilon_simulator_defines.svh"

module nfae_ctrl #(
  parameter int NUM_STATES      = nfae_pkg::DEF_NUM_STATES,
  parameter int MAX_TRANSITIONS = nfae_pkg::DEF_MAX_TRANSITIONS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nfae_in_if.sink                       in_ch,
  nfae_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [nfae_pkg::STATE_W-1:0]  cfg_wdata,
  input  nfae_pkg::entry_t              head_i,
  output nfae_pkg::ring_ctl_t           ring_ctl,
  output logic [(MAX_TRANSITIONS > 1 ? $clog2(MAX_TRANSITIONS) : 1)-1:0] load_idx,
  output nfae_pkg::entry_t              load_data
);

  localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_TRANSITIONS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TRANSITIONS);

  nfae_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]       step_r, step_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  nfae_pkg::func_t        func_r, func_nxt;
  nfae_pkg::entry_t       op_r, op_nxt;
  logic [NUM_STATES-1:0]  set_r, set_nxt;
  logic [NUM_STATES-1:0]  acc_r, acc_nxt;
  logic                   grew_r, grew_nxt;
  logic                   dup_r, dup_nxt;
  nfae_pkg::stat_t        stat_r, stat_nxt;
  logic [nfae_pkg::STATE_W-1:0] fin_r;
  logic                   ov_r, ov_nxt;
  logic                   oacc_r, oemp_r;
  logic [nfae_pkg::STAT_W-1:0] ostat_r;

  logic [nfae_pkg::MAX_STATES-1:0] ext_set;
  logic [NUM_STATES-1:0] to_bit;
  logic [NUM_STATES-1:0] clos_set;
  logic live, from_on, hit_eps, hit_mv, hit_dup, last, grew_now, out_free, take_in;
  logic in_pass, finish_go, wr_go;

  // head cell evaluation
  assign ext_set  = nfae_pkg::MAX_STATES'(set_r);
  assign live     = CNT_W'(step_r) < cnt_r;
  assign from_on  = ext_set[head_i.from_state];
  assign to_bit   = NUM_STATES'(nfae_pkg::MAX_STATES'(1) << head_i.to_state);
  assign hit_eps  = live && (head_i.symbol == nfae_pkg::SYM_EPS) && from_on;
  assign hit_mv   = live && (head_i.symbol == op_r.symbol) && from_on;
  assign hit_dup  = live && (head_i == op_r);
  assign last     = (step_r == LAST_STEP);
  assign clos_set = set_r | (hit_eps ? to_bit : '0);
  assign grew_now = (clos_set != set_r);
  assign out_free = !ov_r || out_ch.ready;
  assign take_in  = in_ch.valid && (state_r == nfae_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfae_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.func)
            nfae_pkg::FN_ADD: begin
              state_nxt = (in_ch.symbol > nfae_pkg::SYM_EPS) ? nfae_pkg::ST_FINISH
                                                             : nfae_pkg::ST_DUP;
            end
            nfae_pkg::FN_START: state_nxt = nfae_pkg::ST_CLOSE;
            nfae_pkg::FN_CHAR: begin
              state_nxt = (in_ch.symbol < nfae_pkg::SYM_LETTERS) ? nfae_pkg::ST_MOVE
                                                                 : nfae_pkg::ST_FINISH;
            end
            default: state_nxt = nfae_pkg::ST_FINISH;
          endcase
        end
      end
      nfae_pkg::ST_DUP:   if (last) state_nxt = nfae_pkg::ST_FINISH;
      nfae_pkg::ST_MOVE:  if (last) state_nxt = nfae_pkg::ST_CLOSE;
      nfae_pkg::ST_CLOSE: if (last && !(grew_r || grew_now)) state_nxt = nfae_pkg::ST_FINISH;
      nfae_pkg::ST_FINISH: if (out_free) state_nxt = nfae_pkg::ST_IDLE;
      default: state_nxt = nfae_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_pass   = (state_r == nfae_pkg::ST_DUP) || (state_r == nfae_pkg::ST_MOVE) ||
                (state_r == nfae_pkg::ST_CLOSE);
    finish_go = (state_r == nfae_pkg::ST_FINISH) && out_free;
    wr_go     = finish_go && (func_r == nfae_pkg::FN_ADD) && (stat_r == nfae_pkg::STAT_OK);
    ring_ctl.shift = in_pass;
    ring_ctl.load  = wr_go;
    in_ch.ready    = (state_r == nfae_pkg::ST_IDLE);
  end

  assign load_idx  = cnt_r[IDX_W-1:0];
  assign load_data = op_r;

  // datapath next values
  always_comb begin
    logic [NUM_STATES-1:0] acc_v;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    func_nxt = func_r;
    op_nxt   = op_r;
    set_nxt  = set_r;
    acc_nxt  = acc_r;
    grew_nxt = grew_r;
    dup_nxt  = dup_r;
    stat_nxt = stat_r;
    acc_v    = acc_r | (hit_mv ? to_bit : '0);

    if (in_pass) begin
      step_nxt = last ? '0 : step_r + 1'b1;
    end

    case (state_r)
      nfae_pkg::ST_IDLE: begin
        if (take_in) begin
          func_nxt = nfae_pkg::func_t'(in_ch.func);
          op_nxt   = '{from_state: in_ch.from_state, symbol: in_ch.symbol,
                       to_state: in_ch.to_state};
          stat_nxt = nfae_pkg::STAT_OK;
          dup_nxt  = 1'b0;
          grew_nxt = 1'b0;
          acc_nxt  = '0;
          case (in_ch.func)
            nfae_pkg::FN_ADD: begin
              if (in_ch.symbol > nfae_pkg::SYM_EPS) stat_nxt = nfae_pkg::STAT_DUP;
            end
            nfae_pkg::FN_CLEAR: cnt_nxt = '0;
            nfae_pkg::FN_START: set_nxt = NUM_STATES'(1);
            default: begin
              if (in_ch.symbol > nfae_pkg::SYM_EPS) set_nxt = '0;
            end
          endcase
        end
      end
      nfae_pkg::ST_DUP: begin
        dup_nxt = dup_r || hit_dup;
        if (last) begin
          if (dup_r || hit_dup) begin
            stat_nxt = nfae_pkg::STAT_DUP;
          end else if (cnt_r == FULL_CNT) begin
            stat_nxt = nfae_pkg::STAT_FULL;
          end
        end
      end
      nfae_pkg::ST_MOVE: begin
        acc_nxt = acc_v;
        if (last) begin
          set_nxt  = acc_v;
          grew_nxt = 1'b0;
        end
      end
      nfae_pkg::ST_CLOSE: begin
        set_nxt  = clos_set;
        grew_nxt = last ? 1'b0 : (grew_r || grew_now);
      end
      nfae_pkg::ST_FINISH: begin
        if (wr_go) cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (finish_go) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfae_pkg::ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      set_r   <= '0;
      grew_r  <= 1'b0;
      dup_r   <= 1'b0;
      stat_r  <= nfae_pkg::STAT_OK;
      func_r  <= nfae_pkg::FN_ADD;
      fin_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      set_r   <= set_nxt;
      grew_r  <= grew_nxt;
      dup_r   <= dup_nxt;
      stat_r  <= stat_nxt;
      func_r  <= func_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) fin_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    if (finish_go) begin
      oacc_r  <= ext_set[fin_r];
      oemp_r  <= (set_r == '0);
      ostat_r <= stat_r;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.accept    = oacc_r;
  assign out_ch.set_empty = oemp_r;
  assign out_ch.status    = ostat_r;

  `NFAE_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "entry count past table size")
  `NFAE_ASSERT_IMPL(a_ring_aligned, state_r == nfae_pkg::ST_IDLE, step_r == '0, "ring misaligned at idle")
  `NFAE_ASSERT_NEXT(a_close_grows, state_r == nfae_pkg::ST_CLOSE, (set_r & $past(set_r)) == $past(set_r), "closure lost a state")
  `NFAE_ASSERT_NEXT(a_load_counts, ring_ctl.load, cnt_r == CNT_W'($past(cnt_r) + 1'b1), "table load without count step")

endmodule

@@ src/nfa_epsilon_simulator.sv @@
// Epsilon-NFA simulator top level: transition ring and sequencer
// Usage:
//   in_ch  : valid/ready channel; one transfer per item (func, from_state,
//            to_state, symbol). func add stores a transition, clear empties
//            the table, start loads the epsilon closure of state 0, char
//            steps the active set on one letter (epsilon keeps it, others empty it).
//   out_ch : valid/ready channel; exactly one result per item (accept,
//            set_empty, status).
//   cfg_we/cfg_wdata : writes final_state; write only while the block idles.
// The table lives in a ring of MAX_TRANSITIONS cells that rotates one place
// per cycle during a pass, past a single evaluation point, and the ring is
// back in place after each full pass.
// Work per item, after the input transfer:
//   clear, invalid add, epsilon or other char : no table pass
//   add        : one duplicate-scan pass
//   start      : P closure passes
//   letter char: one move pass, then P closure passes, where P is the
//                number of passes until one adds no state (at most NUM_STATES).
// One item is worked at a time; in_ch.ready is high only while idle.
// A finished result sits in the output register; if out_ch stalls, the block
// still takes the next item and holds its result until the register frees.
// Reset (synchronous, rst_n low) empties the table and active set, sets
// final_state to 0; table cells themselves are not cleared.
module nfa_epsilon_simulator #(
  parameter int NUM_STATES      = nfae_pkg::DEF_NUM_STATES,
  parameter int MAX_TRANSITIONS = nfae_pkg::DEF_MAX_TRANSITIONS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nfae_in_if.sink                      in_ch,
  nfae_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [nfae_pkg::STATE_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;

  nfae_pkg::entry_t    ring [MAX_TRANSITIONS];
  nfae_pkg::ring_ctl_t ring_ctl;
  logic [IDX_W-1:0]    load_idx;
  nfae_pkg::entry_t    load_data;

  nfae_ctrl #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head_i    (ring[0]),
    .ring_ctl  (ring_ctl),
    .load_idx  (load_idx),
    .load_data (load_data)
  );

  // cell k takes its neighbor k+1; the last cell wraps to the head
  for (genvar k = 0; k < MAX_TRANSITIONS; k++) begin : g_cell
    nfae_cell #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .CELL_IDX        (k)
    ) u_cell (
      .clk       (clk),
      .ctl       (ring_ctl),
      .load_idx  (load_idx),
      .load_data (load_data),
      .nbr_i     (ring[(k + 1) % MAX_TRANSITIONS]),
      .entry_o   (ring[k])
    );
  end

endmodule

@@ bench/nfae_verdict_checker.sv @@
// Transfer monitor, automaton predictor and result comparison for the epsilon-NFA simulator
module nfae_verdict_checker
  import nfae_pkg::*;
#(
  parameter int NUM_STATES      = DEF_NUM_STATES,
  parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  nfae_in_if                 in_mon,
  nfae_out_if                out_mon,
  input  logic               cfg_we,
  input  logic [STATE_W-1:0] cfg_wdata,
  input  logic               wrap_up,
  output int                 outstanding,
  output int                 n_mismatch
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 60;
  localparam logic [MAX_STATES-1:0] STATE_MASK =
    (NUM_STATES >= MAX_STATES) ? {MAX_STATES{1'b1}}
                               : ((64'd1 << NUM_STATES) - 64'd1);

  typedef struct packed {
    logic  accept;
    logic  set_empty;
    stat_t status;
  } verdict_t;

  // predictor state
  logic [STATE_W-1:0]    tab_from [MAX_TRANSITIONS];
  logic [SYM_W-1:0]      tab_sym  [MAX_TRANSITIONS];
  logic [STATE_W-1:0]    tab_to   [MAX_TRANSITIONS];
  int                    n_entries;
  logic [MAX_STATES-1:0] active;
  logic [STATE_W-1:0]    fin_state;

  verdict_t pending_verdicts[$];
  int       n_results;
  bit       leftover_done;

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
    if (n_mismatch == PRINT_CAP) $display("further mismatches are counted only");
  endtask

  function automatic logic [MAX_STATES-1:0] state_bit(input logic [STATE_W-1:0] s);
    return (64'd1 << s) & STATE_MASK;
  endfunction

  // grow along epsilon entries until nothing changes
  function automatic logic [MAX_STATES-1:0] eps_closure(input logic [MAX_STATES-1:0] s);
    logic [MAX_STATES-1:0] prev;
    do begin
      prev = s;
      for (int i = 0; i < n_entries; i++) begin
        if (tab_sym[i] == SYM_EPS && (s & state_bit(tab_from[i])) != '0)
          s |= state_bit(tab_to[i]);
      end
    end while (s != prev);
    return s;
  endfunction

  function automatic logic [MAX_STATES-1:0] letter_image(input logic [MAX_STATES-1:0] s,
                                                        input logic [SYM_W-1:0] sym);
    logic [MAX_STATES-1:0] img;
    img = '0;
    for (int i = 0; i < n_entries; i++) begin
      if (tab_sym[i] == sym && (s & state_bit(tab_from[i])) != '0)
        img |= state_bit(tab_to[i]);
    end
    return img;
  endfunction

  // invalid symbol and duplicate both refuse; duplicate wins over full
  function automatic stat_t insert_transition(input logic [STATE_W-1:0] from_s,
                                              input logic [SYM_W-1:0] sym,
                                              input logic [STATE_W-1:0] to_s);
    if (sym > SYM_EPS) return STAT_DUP;
    for (int i = 0; i < n_entries; i++) begin
      if (tab_from[i] == from_s && tab_sym[i] == sym && tab_to[i] == to_s) return STAT_DUP;
    end
    if (n_entries >= MAX_TRANSITIONS) return STAT_FULL;
    tab_from[n_entries] = from_s;
    tab_sym[n_entries]  = sym;
    tab_to[n_entries]   = to_s;
    n_entries++;
    return STAT_OK;
  endfunction

  function automatic verdict_t nfa_step(input func_t f, input logic [STATE_W-1:0] from_s,
                                        input logic [STATE_W-1:0] to_s,
                                        input logic [SYM_W-1:0] sym);
    verdict_t v;
    v.status = STAT_OK;
    case (f)
      FN_ADD:   v.status = insert_transition(from_s, sym, to_s);
      FN_CLEAR: n_entries = 0;
      FN_START: active = eps_closure(state_bit('0));
      default: begin
        if (sym < SYM_LETTERS) active = eps_closure(letter_image(active, sym));
        else if (sym != SYM_EPS) active = '0;
      end
    endcase
    v.accept    = (fin_state < NUM_STATES) && ((active & state_bit(fin_state)) != '0);
    v.set_empty = (active == '0);
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      n_entries = 0;
      active    = '0;
      fin_state = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) fin_state = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        pending_verdicts.insert(pending_verdicts.size(),
                                nfa_step(func_t'(in_mon.func), in_mon.from_state,
                                         in_mon.to_state, in_mon.symbol));
      if (out_mon.valid && out_mon.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_mon.accept !== want.accept)
            report_mismatch($sformatf("result %0d accept: expected %0b, got %0b",
                                      n_results, want.accept, out_mon.accept));
          if (out_mon.set_empty !== want.set_empty)
            report_mismatch($sformatf("result %0d set_empty: expected %0b, got %0b",
                                      n_results, want.set_empty, out_mon.set_empty));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("result %0d status: expected %s, got %0d",
                                      n_results, want.status.name(), out_mon.status));
        end
        n_results++;
      end
      if (wrap_up && !leftover_done) begin
        leftover_done = 1'b1;
        if (pending_verdicts.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
      end
    end
    outstanding <= pending_verdicts.size();
  end

endmodule

@@ bench/tb_nfa_epsilon_simulator.sv @@
// Top of the epsilon-NFA simulator bench: clock, reset, stimulus and verdict
module tb_nfa_epsilon_simulator;
  import nfae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STATES  = DEF_NUM_STATES;
  localparam int MAX_TR      = DEF_MAX_TRANSITIONS;
  localparam int RAND_ITEMS  = 1900;
  localparam int N_SEGS      = 6;
  localparam int LIGHT_PCT   = 18;
  localparam int HEAVY_PCT   = 87;
  // slowest item: a start/char with the longest closure, plus stall and gap slack
  localparam longint WORST_ITEM  = longint'(NUM_STATES + 2) * MAX_TR + 2 + 400;
  localparam longint CYCLE_LIMIT = 4 * longint'(RAND_ITEMS + 300) * WORST_ITEM;
  localparam int TAIL_CYCLES = 4 * MAX_TR;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [STATE_W-1:0] cfg_wdata;
  logic               wrap_up;
  int                 outstanding;
  int                 n_mismatch;

  nfae_in_if  in_ch ();
  nfae_out_if out_ch ();

  // idle profile, changed per phase
  int tx_idle_pct  = LIGHT_PCT;
  int rx_stall_pct = HEAVY_PCT;

  // bookkeeping for the summary
  int n_items, n_adds, n_clears, n_starts, n_chars;
  int n_progs, n_full_progs, n_settings;
  logic [STATE_W-1:0] fin_cur;
  longint cycle_cnt = 0;

  nfa_epsilon_simulator #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TR)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nfae_verdict_checker #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TR)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .wrap_up     (wrap_up),
    .outstanding (outstanding),
    .n_mismatch  (n_mismatch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure; stall percentage follows the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog: a hung block or a lost handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One input transfer. Random gaps go in front; valid then stays up until ready.
  task automatic send_item(input func_t f, input logic [STATE_W-1:0] from_s,
                           input logic [STATE_W-1:0] to_s, input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.from_state <= from_s;
    in_ch.to_state   <= to_s;
    in_ch.symbol     <= sym;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_items++;
    case (f)
      FN_ADD:   n_adds++;
      FN_CLEAR: n_clears++;
      FN_START: n_starts++;
      default:  n_chars++;
    endcase
  endtask

  // Drain, then write final_state while the block sits idle.
  // Every item yields a result, so no extra settling is needed after the drain.
  task automatic retune(input logic [STATE_W-1:0] v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    fin_cur = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // One automaton: clear, load transitions over a small state pool and a few
  // letters so strings actually walk the graph, then run several strings.
  // Every fifteenth automaton is loaded past capacity with wide-range states.
  task automatic run_program();
    logic [STATE_W-1:0] pool [8];
    entry_t             loaded [$];
    entry_t             e;
    int                 pool_n, lo, span, n_load, n_str, n_len, r;
    bit                 overfill;
    logic [SYM_W-1:0]   sym;

    overfill = (n_progs % 15 == 7);
    n_progs++;
    if (overfill) n_full_progs++;
    pool_n  = $urandom_range(2, 8);
    pool[0] = '0;
    pool[1] = fin_cur;
    for (int i = 2; i < 8; i++) pool[i] = STATE_W'($urandom_range(NUM_STATES - 1));
    lo   = $urandom_range(0, 23);
    span = $urandom_range(0, 2);

    send_item(FN_CLEAR, STATE_W'($urandom_range(63)), STATE_W'($urandom_range(63)),
              SYM_W'($urandom_range(31)));

    // an overfilled table gets only fresh valid entries so it really fills up
    n_load = overfill ? MAX_TR + $urandom_range(2, 6) : $urandom_range(1, 24);
    for (int k = 0; k < n_load; k++) begin
      r = $urandom_range(99);
      if (!overfill && loaded.size() != 0 && r < 6) begin
        e = loaded[$urandom_range(loaded.size() - 1)];
      end else if (!overfill && r < 10) begin
        e.from_state = STATE_W'($urandom_range(63));
        e.symbol     = SYM_W'($urandom_range(27, 31));
        e.to_state   = STATE_W'($urandom_range(63));
      end else if (overfill) begin
        e.from_state = STATE_W'($urandom_range(63));
        e.symbol     = SYM_W'($urandom_range(26));
        e.to_state   = STATE_W'($urandom_range(63));
      end else begin
        e.from_state = pool[$urandom_range(pool_n - 1)];
        e.symbol     = ($urandom_range(99) < 30) ? SYM_EPS : SYM_W'(lo + $urandom_range(span));
        e.to_state   = pool[$urandom_range(pool_n - 1)];
      end
      send_item(FN_ADD, e.from_state, e.to_state, e.symbol);
      loaded.insert(loaded.size(), e);
    end
    // on a full table a repeat must still come back as a duplicate
    if (overfill) begin
      e = loaded[0];
      send_item(FN_ADD, e.from_state, e.to_state, e.symbol);
    end

    n_str = $urandom_range(1, 4);
    for (int s = 0; s < n_str; s++) begin
      send_item(FN_START, STATE_W'($urandom_range(63)), STATE_W'($urandom_range(63)),
                SYM_W'($urandom_range(31)));
      n_len = $urandom_range(0, 7);
      for (int c = 0; c < n_len; c++) begin
        r = $urandom_range(99);
        if (r < 80)      sym = SYM_W'(lo + $urandom_range(span));
        else if (r < 87) sym = SYM_EPS;
        else if (r < 92) sym = SYM_W'($urandom_range(27, 31));
        else             sym = SYM_W'($urandom_range(25));
        send_item(FN_CHAR, STATE_W'($urandom_range(63)), STATE_W'($urandom_range(63)), sym);
      end
    end

    // noise: arbitrary items, including stray clears and chars on a stale set
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 3))
        send_item(func_t'($urandom_range(3)), STATE_W'($urandom_range(63)),
                  STATE_W'($urandom_range(63)), SYM_W'($urandom_range(31)));
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FN_ADD;
    in_ch.from_state <= '0;
    in_ch.to_state   <= '0;
    in_ch.symbol     <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    wrap_up          <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, accepting state at the top of the range
    retune(6'd63);
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd0);      // letter on empty set, empty table
    send_item(FN_START, 6'd0,  6'd0,  5'd0);      // closure of state 0 alone
    send_item(FN_ADD,   6'd0,  6'd63, SYM_EPS);   // 0 -eps-> 63
    send_item(FN_ADD,   6'd0,  6'd63, SYM_EPS);   // exact duplicate, refused
    send_item(FN_ADD,   6'd0,  6'd63, 5'd27);     // invalid symbol, refused
    send_item(FN_ADD,   6'd63, 6'd0,  5'd31);     // invalid symbol, all ones
    send_item(FN_ADD,   6'd63, 6'd1,  5'd25);     // 63 -z-> 1
    send_item(FN_ADD,   6'd1,  6'd63, 5'd0);      // 1 -a-> 63
    send_item(FN_ADD,   6'd63, 6'd62, SYM_EPS);   // chained epsilon
    send_item(FN_START, 6'd63, 6'd63, 5'd31);     // accepts through epsilon
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd25);     // z
    send_item(FN_CHAR,  6'd0,  6'd0,  SYM_EPS);   // '#' keeps the set
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd0);      // a, back to accepting
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd27);     // other character empties
    send_item(FN_START, 6'd0,  6'd0,  5'd0);
    send_item(FN_CLEAR, 6'd63, 6'd63, 5'd31);     // table gone, set kept
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd25);     // no transitions left
    send_item(FN_START, 6'd0,  6'd0,  5'd0);
    send_item(FN_CHAR,  6'd0,  6'd0,  5'd31);     // other character, all ones
    send_item(FN_ADD,   6'd62, 6'd0,  SYM_EPS);
    send_item(FN_CHAR,  6'd63, 6'd63, SYM_EPS);   // '#' on an empty set

    // random part: two phases per idle profile, the final state set anew each phase
    for (int seg = 0; seg < N_SEGS; seg++) begin
      case (seg)
        0, 4:    retune('0);
        2:       retune(6'd63);
        default: retune(STATE_W'($urandom_range(NUM_STATES - 1)));
      endcase
      if (seg < 2) begin
        tx_idle_pct  = LIGHT_PCT;
        rx_stall_pct = HEAVY_PCT;
      end else if (seg < 4) begin
        tx_idle_pct  = HEAVY_PCT;
        rx_stall_pct = LIGHT_PCT;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      while (n_items < 21 + (seg + 1) * RAND_ITEMS / N_SEGS) run_program();
    end

    // drain, then give a stray late result time to show up
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Ran %0d items: %0d adds, %0d clears, %0d starts, %0d characters",
             n_items, n_adds, n_clears, n_starts, n_chars);
    $display("%0d automata (%0d loaded past capacity), %0d final-state settings, %0d cycles",
             n_progs, n_full_progs, n_settings, cycle_cnt);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
